### hdl/zmodem_data_phase_receiver_unit_macros.svh
// ----------------------------------------------------------------------------
// ZMODEM data phase receiver - assertion macros
// Shared concurrent check wrappers clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef ZMODEM_DATA_PHASE_RECEIVER_UNIT_MACROS_SVH
`define ZMODEM_DATA_PHASE_RECEIVER_UNIT_MACROS_SVH

// property holds at every clock
`define ZDPR_CHECK(name, prop) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("zdpr check failed");

// consequent holds in the cycle after the antecedent
`define ZDPR_CHECK_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("zdpr sequence check failed");

`endif

### hdl/zdpr_pkg.sv
// ----------------------------------------------------------------------------
// ZMODEM data phase receiver - package
// Field widths, request class codes, result codes and the queue entry type.
// ----------------------------------------------------------------------------
package zdpr_pkg;

    localparam int POS_W         = 32;
    localparam int LEN_W         = 11;
    localparam int CODE_W        = 5;
    localparam int LIMIT_W       = 4;
    localparam int MAX_SUBPACKET = 1024;
    localparam int RETRY_RESET   = 10;
    localparam int QUEUE_DEPTH   = 2;

    // input opcodes
    localparam logic [1:0] OP_START   = 2'd0;
    localparam logic [1:0] OP_TIMEOUT = 2'd1;
    localparam logic [1:0] OP_HEADER  = 2'd2;
    localparam logic [1:0] OP_SUBPKT  = 2'd3;

    // header kinds
    localparam logic [1:0] HK_EOF   = 2'd0;
    localparam logic [1:0] HK_FILE  = 2'd1;
    localparam logic [1:0] HK_DATA  = 2'd2;
    localparam logic [1:0] HK_OTHER = 2'd3;

    // subpacket status
    localparam logic [1:0] SS_MORE   = 2'd0;
    localparam logic [1:0] SS_EOF    = 2'd1;
    localparam logic [1:0] SS_BAD    = 2'd2;
    localparam logic [1:0] SS_CANCEL = 2'd3;

    // subpacket frame ends
    localparam logic [1:0] FE_CRCE = 2'd0;
    localparam logic [1:0] FE_CRCG = 2'd1;
    localparam logic [1:0] FE_CRCQ = 2'd2;
    localparam logic [1:0] FE_CRCW = 2'd3;

    // request classes
    localparam logic [2:0] EV_START     = 3'd0;
    localparam logic [2:0] EV_TIMEOUT   = 3'd1;
    localparam logic [2:0] EV_HDR_EOF   = 3'd2;
    localparam logic [2:0] EV_HDR_FILE  = 3'd3;
    localparam logic [2:0] EV_HDR_DATA  = 3'd4;
    localparam logic [2:0] EV_HDR_OTHER = 3'd5;
    localparam logic [2:0] EV_SUBPKT    = 3'd6;

    // actions
    localparam logic [1:0] ACT_NONE   = 2'd0;
    localparam logic [1:0] ACT_RESEND = 2'd1;
    localparam logic [1:0] ACT_ACK    = 2'd2;
    localparam logic [1:0] ACT_FERR   = 2'd3;

    // finish status
    localparam logic [2:0] FS_EOF      = 3'd0;
    localparam logic [2:0] FS_TIMEOUTS = 3'd1;
    localparam logic [2:0] FS_MISMATCH = 3'd2;
    localparam logic [2:0] FS_BADSUB   = 3'd3;
    localparam logic [2:0] FS_CANCEL   = 3'd4;
    localparam logic [2:0] FS_UNEXPECT = 3'd5;
    localparam logic [2:0] FS_OVERFLOW = 3'd6;

    typedef struct packed {
        logic [2:0]        ev_kind;
        logic [POS_W-1:0]  position;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  length;
        logic              cancel;
        logic              bad;
        logic              sub_last;
        logic              ack;
    } t_cmd;

endpackage

### hdl/zdpr_front.sv
// ----------------------------------------------------------------------------
// ZMODEM data phase receiver - front end
// Accepts requests and classifies them into compact queue entries.
// ----------------------------------------------------------------------------
module zdpr_front (
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_opcode,
    input  logic [zdpr_pkg::POS_W-1:0]   i_start_position,
    input  logic [1:0]                   i_header_kind,
    input  logic [zdpr_pkg::POS_W-1:0]   i_header_position,
    input  logic [zdpr_pkg::CODE_W-1:0]  i_other_header_code,
    input  logic [1:0]                   i_subpacket_status,
    input  logic [zdpr_pkg::LEN_W-1:0]   i_subpacket_length,
    input  logic [1:0]                   i_subpacket_end,
    input  logic                         i_full,
    output logic                         o_push,
    output zdpr_pkg::t_cmd               o_cmd
);

    logic w_overlong;

    assign w_overlong = ({{(zdpr_pkg::POS_W-zdpr_pkg::LEN_W){1'b0}}, i_subpacket_length}
                         > zdpr_pkg::POS_W'(zdpr_pkg::MAX_SUBPACKET));

    assign o_in_ready = !i_full;
    assign o_push     = i_in_valid && !i_full;

    always_comb begin
        o_cmd           = '0;
        o_cmd.code      = i_other_header_code;
        o_cmd.length    = i_subpacket_length;
        o_cmd.cancel    = (i_subpacket_status == zdpr_pkg::SS_CANCEL);
        o_cmd.bad       = (i_subpacket_status == zdpr_pkg::SS_BAD) || w_overlong;
        o_cmd.sub_last  = (i_subpacket_status == zdpr_pkg::SS_EOF);
        o_cmd.ack       = (i_subpacket_end == zdpr_pkg::FE_CRCQ)
                          || (i_subpacket_end == zdpr_pkg::FE_CRCW);
        o_cmd.position  = i_header_position;
        unique case (i_opcode)
            zdpr_pkg::OP_START: begin
                o_cmd.ev_kind  = zdpr_pkg::EV_START;
                o_cmd.position = i_start_position;
            end
            zdpr_pkg::OP_TIMEOUT: o_cmd.ev_kind = zdpr_pkg::EV_TIMEOUT;
            zdpr_pkg::OP_HEADER: begin
                unique case (i_header_kind)
                    zdpr_pkg::HK_EOF:  o_cmd.ev_kind = zdpr_pkg::EV_HDR_EOF;
                    zdpr_pkg::HK_FILE: o_cmd.ev_kind = zdpr_pkg::EV_HDR_FILE;
                    zdpr_pkg::HK_DATA: o_cmd.ev_kind = zdpr_pkg::EV_HDR_DATA;
                    default:           o_cmd.ev_kind = zdpr_pkg::EV_HDR_OTHER;
                endcase
            end
            default: o_cmd.ev_kind = zdpr_pkg::EV_SUBPKT;
        endcase
    end

endmodule

### hdl/zdpr_queue.sv
// ----------------------------------------------------------------------------
// ZMODEM data phase receiver - command queue
// Small FIFO of classified requests between front end and executor.
// ----------------------------------------------------------------------------
module zdpr_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  zdpr_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_nonempty,
    output zdpr_pkg::t_cmd o_cmd
);

    localparam int AW = (zdpr_pkg::QUEUE_DEPTH > 1) ? $clog2(zdpr_pkg::QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(zdpr_pkg::QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(zdpr_pkg::QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] FULL = CW'(zdpr_pkg::QUEUE_DEPTH);

    zdpr_pkg::t_cmd r_entry [zdpr_pkg::QUEUE_DEPTH];
    logic [AW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [AW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [CW-1:0]  r_count, n_count;

    assign o_full     = (r_count == FULL);
    assign o_nonempty = (r_count != '0);
    assign o_cmd      = r_entry[r_rd_ptr];

    always_comb begin
        n_rd_ptr = r_rd_ptr;
        n_wr_ptr = r_wr_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

### hdl/zdpr_back.sv
// ----------------------------------------------------------------------------
// ZMODEM data phase receiver - executor
// Applies queued requests to the phase state and registers one result each.
// ----------------------------------------------------------------------------
`include "zmodem_data_phase_receiver_unit_macros.svh"

module zdpr_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [zdpr_pkg::LIMIT_W-1:0] i_cfg_wdata,
    input  logic                         i_nonempty,
    input  zdpr_pkg::t_cmd               i_cmd,
    output logic                         o_pop,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [1:0]                   o_action,
    output logic [zdpr_pkg::POS_W-1:0]   o_action_position,
    output logic [zdpr_pkg::LEN_W-1:0]   o_commit_length,
    output logic                         o_finished,
    output logic [2:0]                   o_finish_status,
    output logic [zdpr_pkg::CODE_W-1:0]  o_finish_header_code
);

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_HEADER = 3'd1;
    localparam logic [2:0] PH_FINFO  = 3'd2;
    localparam logic [2:0] PH_DATA   = 3'd3;

    localparam int PW = zdpr_pkg::POS_W;
    localparam int LW = zdpr_pkg::LIMIT_W;

    logic [2:0]    r_phase, n_phase;
    logic [PW-1:0] r_exp, n_exp;
    logic [LW-1:0] r_err, n_err;
    logic [LW-1:0] r_retry_limit;

    logic                         r_out_valid;
    logic [1:0]                   r_action, n_action;
    logic [PW-1:0]                r_pos, n_pos;
    logic [zdpr_pkg::LEN_W-1:0]   r_len, n_len;
    logic                         r_fin, n_fin;
    logic [2:0]                   r_status, n_status;
    logic [zdpr_pkg::CODE_W-1:0]  r_code, n_code;

    logic [LW:0]   w_err_inc;
    logic          w_give_up;
    logic [PW:0]   w_sum;
    logic          w_do_err;
    logic [2:0]    w_err_status;
    logic          w_hdr;

    assign o_pop     = i_nonempty && (!r_out_valid || i_out_ready);
    assign w_err_inc = {1'b0, r_err} + 1'b1;
    assign w_give_up = (w_err_inc >= {1'b0, r_retry_limit});
    assign w_sum     = {1'b0, r_exp} + {{(PW + 1 - zdpr_pkg::LEN_W){1'b0}}, i_cmd.length};
    assign w_hdr     = (r_phase == PH_HEADER);

    always_comb begin
        n_phase      = r_phase;
        n_exp        = r_exp;
        n_err        = r_err;
        n_action     = zdpr_pkg::ACT_NONE;
        n_pos        = '0;
        n_len        = '0;
        n_fin        = 1'b0;
        n_status     = zdpr_pkg::FS_EOF;
        n_code       = '0;
        w_do_err     = 1'b0;
        w_err_status = zdpr_pkg::FS_EOF;
        unique case (i_cmd.ev_kind)
            zdpr_pkg::EV_START: begin
                n_exp    = i_cmd.position;
                n_err    = '0;
                n_phase  = PH_HEADER;
                n_action = zdpr_pkg::ACT_RESEND;
                n_pos    = i_cmd.position;
            end
            zdpr_pkg::EV_TIMEOUT: begin
                if (w_hdr) begin
                    w_do_err     = 1'b1;
                    w_err_status = zdpr_pkg::FS_TIMEOUTS;
                end
            end
            zdpr_pkg::EV_HDR_EOF: begin
                if (w_hdr && (i_cmd.position == r_exp)) begin
                    n_phase = PH_IDLE;
                    n_fin   = 1'b1;
                end
            end
            zdpr_pkg::EV_HDR_FILE: begin
                if (w_hdr) begin
                    n_phase = PH_FINFO;
                end
            end
            zdpr_pkg::EV_HDR_DATA: begin
                if (w_hdr) begin
                    if (i_cmd.position != r_exp) begin
                        w_do_err     = 1'b1;
                        w_err_status = zdpr_pkg::FS_MISMATCH;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end
            end
            zdpr_pkg::EV_HDR_OTHER: begin
                if (w_hdr) begin
                    n_phase  = PH_IDLE;
                    n_fin    = 1'b1;
                    n_status = zdpr_pkg::FS_UNEXPECT;
                    n_code   = i_cmd.code;
                end
            end
            zdpr_pkg::EV_SUBPKT: begin
                if (r_phase == PH_FINFO) begin
                    if (i_cmd.cancel) begin
                        n_phase  = PH_IDLE;
                        n_fin    = 1'b1;
                        n_status = zdpr_pkg::FS_CANCEL;
                    end else begin
                        n_phase  = PH_HEADER;
                        n_action = zdpr_pkg::ACT_RESEND;
                        n_pos    = r_exp;
                    end
                end else if (r_phase == PH_DATA) begin
                    if (i_cmd.cancel) begin
                        n_phase  = PH_IDLE;
                        n_fin    = 1'b1;
                        n_status = zdpr_pkg::FS_CANCEL;
                    end else if (i_cmd.bad) begin
                        w_do_err     = 1'b1;
                        w_err_status = zdpr_pkg::FS_BADSUB;
                    end else if (w_sum[PW]) begin
                        n_phase  = PH_IDLE;
                        n_fin    = 1'b1;
                        n_status = zdpr_pkg::FS_OVERFLOW;
                        n_action = zdpr_pkg::ACT_FERR;
                        n_pos    = r_exp;
                    end else begin
                        n_exp = w_sum[PW-1:0];
                        n_err = '0;
                        n_len = i_cmd.length;
                        if (i_cmd.ack) begin
                            n_action = zdpr_pkg::ACT_ACK;
                            n_pos    = w_sum[PW-1:0];
                        end
                        if (i_cmd.sub_last) begin
                            n_phase = PH_HEADER;
                        end
                    end
                end
            end
            default: ;
        endcase
        if (w_do_err) begin
            if (w_give_up) begin
                n_err    = w_err_inc[LW] ? {LW{1'b1}} : w_err_inc[LW-1:0];
                n_phase  = PH_IDLE;
                n_fin    = 1'b1;
                n_status = w_err_status;
            end else begin
                n_err    = w_err_inc[LW-1:0];
                n_phase  = PH_HEADER;
                n_action = zdpr_pkg::ACT_RESEND;
                n_pos    = r_exp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_exp         <= '0;
            r_err         <= '0;
            r_retry_limit <= LW'(zdpr_pkg::RETRY_RESET);
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_retry_limit <= i_cfg_wdata;
            end
            if (o_pop) begin
                r_phase     <= n_phase;
                r_exp       <= n_exp;
                r_err       <= n_err;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_action <= n_action;
            r_pos    <= n_pos;
            r_len    <= n_len;
            r_fin    <= n_fin;
            r_status <= n_status;
            r_code   <= n_code;
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_action             = r_action;
    assign o_action_position    = r_pos;
    assign o_commit_length      = r_len;
    assign o_finished           = r_fin;
    assign o_finish_status      = r_status;
    assign o_finish_header_code = r_code;

    // finishing never resends or acks
    `ZDPR_CHECK(a_fin_action, (r_out_valid && r_fin) |->
        (r_action == zdpr_pkg::ACT_NONE || r_action == zdpr_pkg::ACT_FERR))
    // a finished request leaves the phase idle
    `ZDPR_CHECK_NEXT(a_fin_idle, o_pop && n_fin, r_phase == PH_IDLE)
    // committed bytes only on a good, unfinished subpacket
    `ZDPR_CHECK(a_commit_ok, (r_out_valid && r_len != '0) |->
        (!r_fin && r_len <= zdpr_pkg::LEN_W'(zdpr_pkg::MAX_SUBPACKET)))
    // a held result is not overwritten without a pop
    `ZDPR_CHECK_NEXT(a_hold, r_out_valid && !i_out_ready && !o_pop,
        r_out_valid && $stable(r_pos))

endmodule

### hdl/zmodem_data_phase_receiver_unit.sv
// Requests enter the command queue; the executor pops each and registers its result.
// Throughput: one request per cycle unless a held result stalls; the executor updates
// phase, position and error count once per request, fed from a two-entry command queue.
// Reset: i_rst_n low at a clock edge clears the queue and the output register, sets
// the phase idle, position and error count zero, and the retry limit to 10.
// ----------------------------------------------------------------------------
// ZMODEM data phase receiver - top level
// Front end classifies requests, queue decouples, executor produces results.
// ----------------------------------------------------------------------------
module zmodem_data_phase_receiver_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [zdpr_pkg::LIMIT_W-1:0] i_cfg_wdata,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [1:0]                   i_opcode,
    input  logic [zdpr_pkg::POS_W-1:0]   i_start_position,
    input  logic [1:0]                   i_header_kind,
    input  logic [zdpr_pkg::POS_W-1:0]   i_header_position,
    input  logic [zdpr_pkg::CODE_W-1:0]  i_other_header_code,
    input  logic [1:0]                   i_subpacket_status,
    input  logic [zdpr_pkg::LEN_W-1:0]   i_subpacket_length,
    input  logic [1:0]                   i_subpacket_end,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [1:0]                   o_action,
    output logic [zdpr_pkg::POS_W-1:0]   o_action_position,
    output logic [zdpr_pkg::LEN_W-1:0]   o_commit_length,
    output logic                         o_finished,
    output logic [2:0]                   o_finish_status,
    output logic [zdpr_pkg::CODE_W-1:0]  o_finish_header_code
);

    logic           w_push;
    logic           w_full;
    logic           w_pop;
    logic           w_nonempty;
    zdpr_pkg::t_cmd w_push_cmd;
    zdpr_pkg::t_cmd w_head_cmd;

    zdpr_front u_front (
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_opcode            (i_opcode),
        .i_start_position    (i_start_position),
        .i_header_kind       (i_header_kind),
        .i_header_position   (i_header_position),
        .i_other_header_code (i_other_header_code),
        .i_subpacket_status  (i_subpacket_status),
        .i_subpacket_length  (i_subpacket_length),
        .i_subpacket_end     (i_subpacket_end),
        .i_full              (w_full),
        .o_push              (w_push),
        .o_cmd               (w_push_cmd)
    );

    zdpr_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_cmd      (w_push_cmd),
        .o_full     (w_full),
        .i_pop      (w_pop),
        .o_nonempty (w_nonempty),
        .o_cmd      (w_head_cmd)
    );

    zdpr_back u_back (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_wdata          (i_cfg_wdata),
        .i_nonempty           (w_nonempty),
        .i_cmd                (w_head_cmd),
        .o_pop                (w_pop),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_action             (o_action),
        .o_action_position    (o_action_position),
        .o_commit_length      (o_commit_length),
        .o_finished           (o_finished),
        .o_finish_status      (o_finish_status),
        .o_finish_header_code (o_finish_header_code)
    );

endmodule
